[rtl/core/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and codes of the k-way sorted merge
// Transaction payloads, mode codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int VALUE_W = 32;
	localparam int INDEX_W = 3;
	localparam int MODE_W  = 2;

	// transaction modes
	localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic [INDEX_W-1:0]        list_index;
		logic signed [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] out_value;
		logic                      out_valid;
		logic [INDEX_W-1:0]        source_list;
		logic                      overflow;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_init;
		logic scan_issue;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              scan_last;
		logic              out_free;
	} dp_status_t;

endpackage

[rtl/core/kwm_stream_if.sv]
// ----------------------------------------------------------------------------
// kwm_stream_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface kwm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl: sequencing of one transaction at a time
// Accepts an item, runs the head scan for a pop and commits the result.
// ----------------------------------------------------------------------------
module kwm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  kwm_pkg::dp_status_t    sts,
	output kwm_pkg::ctrl_cmd_t     cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_LAST = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.mode == kwm_pkg::MODE_POP) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/kwm_dpath.sv]
// ----------------------------------------------------------------------------
// kwm_dpath: list storage, head scan and result register
// Holds every list in one shared memory with per-list pointers and counts.
// ----------------------------------------------------------------------------
module kwm_dpath #(
	parameter int LISTS      = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kwm_pkg::ctrl_cmd_t    cmd,
	output kwm_pkg::dp_status_t   sts,
	input  kwm_pkg::in_item_t     in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output kwm_pkg::out_item_t    out_data
);

	localparam int LIST_W    = (LISTS > 1) ? $clog2(LISTS) : 1;
	localparam int PTR_W     = $clog2(LIST_DEPTH);
	localparam int FILL_W    = $clog2(LIST_DEPTH + 1);
	localparam int AW        = LIST_W + PTR_W;
	localparam int MEM_DEPTH = LISTS * (2 ** PTR_W);

	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(LIST_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LIST_DEPTH);
	localparam logic [LIST_W-1:0] LIST_LAST = LIST_W'(LISTS - 1);

	logic [kwm_pkg::VALUE_W-1:0] mem [0:MEM_DEPTH-1];

	logic [PTR_W-1:0]  rp_q   [LISTS];
	logic [PTR_W-1:0]  wp_q   [LISTS];
	logic [FILL_W-1:0] fill_q [LISTS];

	kwm_pkg::in_item_t item_q;

	logic [LIST_W-1:0]                  cnt_q;
	logic                               hit_s1;
	logic [LIST_W-1:0]                  idx_s1;
	logic signed [kwm_pkg::VALUE_W-1:0] data_s1;

	logic                               best_found_q;
	logic [LIST_W-1:0]                  best_idx_q;
	logic signed [kwm_pkg::VALUE_W-1:0] best_val_q;

	logic                               out_valid_q;
	kwm_pkg::out_item_t                 out_data_q;
	kwm_pkg::out_item_t                 res_d;

	logic              idx_ok;
	logic [LIST_W-1:0] push_sel;
	logic              push_full;
	logic              do_push;
	logic              do_pop;
	logic              do_clear;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;

	// decode of the held item
	always_comb begin
		idx_ok    = int'(item_q.list_index) < LISTS;
		push_sel  = LIST_W'(item_q.list_index);
		push_full = fill_q[push_sel] >= FILL_FULL;
		do_push   = cmd.commit && (item_q.mode == kwm_pkg::MODE_PUSH) && idx_ok && !push_full;
		do_pop    = cmd.commit && (item_q.mode == kwm_pkg::MODE_POP) && best_found_q;
		do_clear  = cmd.commit && (item_q.mode == kwm_pkg::MODE_CLEAR);
		wr_addr   = {push_sel, wp_q[push_sel]};
		rd_addr   = {cnt_q, rp_q[cnt_q]};
	end

	assign sts = '{
		mode:      item_q.mode,
		scan_last: (cnt_q == LIST_LAST),
		out_free:  (!out_valid_q || out_ready)
	};

	// item holding register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_data;
		end
	end

	// element memory, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_addr] <= item_q.value;
		end
		if (cmd.scan_issue) begin
			data_s1 <= mem[rd_addr];
		end
	end

	// per-list pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				rp_q[i]   <= '0;
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else if (do_clear) begin
			for (int i = 0; i < LISTS; i++) begin
				rp_q[i]   <= '0;
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else if (do_push) begin
			wp_q[push_sel]   <= (wp_q[push_sel] == PTR_LAST) ? '0 : wp_q[push_sel] + 1'b1;
			fill_q[push_sel] <= fill_q[push_sel] + 1'b1;
		end else if (do_pop) begin
			rp_q[best_idx_q]   <= (rp_q[best_idx_q] == PTR_LAST) ? '0 : rp_q[best_idx_q] + 1'b1;
			fill_q[best_idx_q] <= fill_q[best_idx_q] - 1'b1;
		end
	end

	// scan counter and head read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hit_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			hit_s1 <= cmd.scan_issue && (fill_q[cnt_q] != '0);
			if (cmd.scan_issue) begin
				idx_s1 <= cnt_q;
			end
			if (cmd.scan_init) begin
				cnt_q <= '0;
			end else if (cmd.scan_issue) begin
				cnt_q <= (cnt_q == LIST_LAST) ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// running minimum, strict compare keeps the lowest list on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (cmd.scan_init || cmd.accept) begin
			best_found_q <= 1'b0;
		end else if (hit_s1 && (!best_found_q || (data_s1 < best_val_q))) begin
			best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s1 && (!best_found_q || (data_s1 < best_val_q))) begin
			best_idx_q <= idx_s1;
			best_val_q <= data_s1;
		end
	end

	// result of the held item
	always_comb begin
		res_d = '0;
		if (item_q.mode == kwm_pkg::MODE_PUSH) begin
			res_d.overflow = idx_ok && push_full;
		end else if (do_pop) begin
			res_d.out_value   = best_val_q;
			res_d.out_valid   = 1'b1;
			res_d.source_list = kwm_pkg::INDEX_W'(best_idx_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit while result slot busy");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> (fill_q[best_idx_q] != '0))
		else $error("pop from an empty list");
	a_hit_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> $past(cmd.scan_issue))
		else $error("head compare without a read");
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> (fill_q[$past(push_sel)] <= FILL_FULL))
		else $error("fill count beyond list depth");
`endif

endmodule

[rtl/core/k_way_sorted_merge_top.sv]
// Sequence: push, clear and no-op commit their result without a scan; a pop first runs
// the one-list-per-cycle head scan over the memory read port, then commits its result.
// Flow: one transaction at a time; the next is taken once the current one commits, and
// a commit waits while the previous result still sits unaccepted in the output register.
// Reset: arst_n asynchronously empties every list; stored words stay undefined.
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top: stable k-way merge of sorted lists
// Push appends to a list, pop returns the smallest head, clear empties all.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_top #(
	parameter int LISTS      = 8,
	parameter int LIST_DEPTH = 64
) (
	input logic          clk,
	input logic          arst_n,
	kwm_stream_if.sink   item,
	kwm_stream_if.source result
);

	kwm_pkg::ctrl_cmd_t  cmd;
	kwm_pkg::dp_status_t sts;

	kwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kwm_dpath #(
		.LISTS      (LISTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (item.data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);

endmodule

[tb/sv/kwm_tb_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_tb_pkg: merge scoreboard for the k-way sorted merge bench
// Tracks the per-list contents after every accepted transaction and
// compares each returned result, field by field, in arrival order.
// ----------------------------------------------------------------------------
package kwm_tb_pkg;

	import kwm_pkg::*;

	localparam int TB_LISTS    = 8;
	localparam int TB_DEPTH    = 64;

	class merge_scoreboard;
		logic signed [VALUE_W-1:0] list_words [TB_LISTS][TB_DEPTH];
		int unsigned               head_ptr [TB_LISTS];
		int unsigned               tail_ptr [TB_LISTS];
		int unsigned               occupancy [TB_LISTS];
		out_item_t                 due_results [$];
		int unsigned               mismatches;

		function new();
			mismatches = 0;
			empty_lists();
		endfunction

		function void empty_lists();
			foreach (occupancy[i]) begin
				head_ptr[i]  = 0;
				tail_ptr[i]  = 0;
				occupancy[i] = 0;
			end
		endfunction

		// work out the result of one accepted transaction and queue it
		function void apply_item(in_item_t it);
			out_item_t r;
			int        best;
			int        idx;
			r   = '0;
			idx = int'(it.list_index);
			case (it.mode)
				MODE_PUSH: begin
					if (idx < TB_LISTS) begin
						if (occupancy[idx] >= TB_DEPTH) begin
							r.overflow = 1'b1;
						end else begin
							list_words[idx][tail_ptr[idx]] = it.value;
							tail_ptr[idx]  = (tail_ptr[idx] + 1) % TB_DEPTH;
							occupancy[idx] = occupancy[idx] + 1;
						end
					end
				end
				MODE_POP: begin
					// strict less-than keeps the lowest list on equal heads
					best = -1;
					for (int i = 0; i < TB_LISTS; i++) begin
						if (occupancy[i] != 0) begin
							if (best < 0 ||
								list_words[i][head_ptr[i]] < list_words[best][head_ptr[best]])
								best = i;
						end
					end
					if (best >= 0) begin
						r.out_value   = list_words[best][head_ptr[best]];
						r.out_valid   = 1'b1;
						r.source_list = best[INDEX_W-1:0];
						head_ptr[best]  = (head_ptr[best] + 1) % TB_DEPTH;
						occupancy[best] = occupancy[best] - 1;
					end
				end
				MODE_CLEAR: begin
					empty_lists();
				end
				default: begin
				end
			endcase
			due_results.insert(due_results.size(), r);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("mismatch: %s", what);
		endtask

		// compare one returned result against the oldest pending one
		task check_result(out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, value %0d",
					got.out_value));
				return;
			end
			want = due_results.pop_front();
			if (got.out_value !== want.out_value)
				report_mismatch($sformatf("out_value %0d, wanted %0d",
					got.out_value, want.out_value));
			if (got.out_valid !== want.out_valid)
				report_mismatch($sformatf("out_valid %b, wanted %b",
					got.out_valid, want.out_valid));
			if (got.source_list !== want.source_list)
				report_mismatch($sformatf("source_list %0d, wanted %0d",
					got.source_list, want.source_list));
			if (got.overflow !== want.overflow)
				report_mismatch($sformatf("overflow %b, wanted %b",
					got.overflow, want.overflow));
		endtask

		function int fill_of(int i);
			return int'(occupancy[i]);
		endfunction

		function int fill_total();
			int sum;
			sum = 0;
			foreach (occupancy[i])
				sum += int'(occupancy[i]);
			return sum;
		endfunction

		function bit drained();
			return due_results.size() == 0;
		endfunction
	endclass

endpackage

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: bench for the k-way sorted merge
// Drives pushes, pops, clears and no-ops with random gaps and back-pressure,
// mostly as sorted runs into several lists that are then merged out, and
// checks every result against the merge scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

	import kwm_pkg::*;
	import kwm_tb_pkg::*;

	localparam int     POP_LATENCY = TB_LISTS + 4;
	localparam longint CYCLE_LIMIT = 1_000_000;
	localparam int     TOTAL_ITEMS = 1925;
	localparam int     PHASE_ITEMS = 200;
	localparam longint VMAX        = 64'sd2147483647;
	localparam longint VMIN        = -64'sd2147483648;

	logic clk;
	logic arst_n;

	kwm_stream_if #(.T(in_item_t))  item_if ();
	kwm_stream_if #(.T(out_item_t)) result_if ();

	k_way_sorted_merge_top #(
		.LISTS      (TB_LISTS),
		.LIST_DEPTH (TB_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	merge_scoreboard merge_sb;
	int unsigned     sender_idle_pct = 0;
	int unsigned     sink_stall_pct  = 0;
	int unsigned     items_sent      = 0;
	longint          cycle_count     = 0;
	longint          last_val [TB_LISTS];

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// result side: check accepted transactions, then pick the next ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready)
				merge_sb.check_result(result_if.data);
			result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// idle and stall mix follows the number of transactions sent
	task automatic pick_phase();
		case ((items_sent / PHASE_ITEMS) % 4)
			0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin sender_idle_pct = 66; sink_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  sink_stall_pct = 66; end
			default: begin sender_idle_pct = 30; sink_stall_pct = 30; end
		endcase
	endtask

	// one transaction on the item channel; called at a rising edge
	task automatic send_item(input logic [MODE_W-1:0] mode, input int idx,
		input longint val);
		in_item_t it;
		it.mode       = mode;
		it.list_index = idx[INDEX_W-1:0];
		it.value      = val[VALUE_W-1:0];
		while ($urandom_range(99) < sender_idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.data  <= it;
		do
			@(posedge clk);
		while (!item_if.ready);
		merge_sb.apply_item(it);
		items_sent++;
		pick_phase();
	endtask

	task automatic push(input int idx, input longint val);
		send_item(MODE_PUSH, idx, val);
	endtask

	task automatic pop();
		send_item(MODE_POP, $urandom_range(TB_LISTS - 1), longint'($signed($urandom)));
	endtask

	// starting points of sorted runs, extremes and shared values included
	function automatic longint fresh_base();
		case ($urandom_range(4))
			0:       return VMIN + $urandom_range(3);
			1:       return longint'($signed($urandom));
			2:       return 0;
			3:       return longint'($urandom_range(8)) - 4;
			default: return VMAX - $urandom_range(3);
		endcase
	endfunction

	// next element of a non-decreasing run, saturating at the top
	function automatic longint next_sorted(longint prev);
		longint n;
		case ($urandom_range(3))
			0:       n = prev;
			1:       n = prev + $urandom_range(1, 4);
			2:       n = prev + $urandom_range(0, 1 << 24);
			default: n = prev + $urandom_range(0, 1 << 30);
		endcase
		return (n > VMAX) ? VMAX : n;
	endfunction

	task automatic push_sorted(input int idx);
		last_val[idx] = next_sorted(last_val[idx]);
		push(idx, last_val[idx]);
	endtask

	// sorted runs into a random set of lists, interleaved, then drain all
	task automatic merge_round();
		int     run_len [TB_LISTS];
		int     left;
		int     pick;
		int     pops;
		longint shared_base;
		left        = 0;
		shared_base = fresh_base();
		for (int i = 0; i < TB_LISTS; i++) begin
			run_len[i] = $urandom_range(1) ? $urandom_range(9) : 0;
			left += run_len[i];
			if (merge_sb.fill_of(i) == 0)
				last_val[i] = ($urandom_range(3) == 0) ? fresh_base() : shared_base;
		end
		while (left > 0) begin
			pick = $urandom_range(TB_LISTS - 1);
			if (run_len[pick] == 0)
				continue;
			push_sorted(pick);
			run_len[pick]--;
			left--;
		end
		pops = merge_sb.fill_total() + $urandom_range(1);
		repeat (pops) pop();
	endtask

	// pushes and pops interleaved while lists are partly drained
	task automatic mixed_round();
		int pick;
		repeat ($urandom_range(20, 40)) begin
			if ($urandom_range(1)) begin
				pick = $urandom_range(TB_LISTS - 1);
				if (merge_sb.fill_of(pick) == 0)
					last_val[pick] = fresh_base();
				push_sorted(pick);
			end else begin
				pop();
			end
		end
	endtask

	// fill one list past its depth, then clear or drain
	task automatic overflow_round();
		int pick;
		pick = $urandom_range(TB_LISTS - 1);
		if (merge_sb.fill_of(pick) == 0)
			last_val[pick] = fresh_base();
		while (merge_sb.fill_of(pick) < TB_DEPTH)
			push_sorted(pick);
		repeat ($urandom_range(1, 3)) push_sorted(pick);
		if ($urandom_range(1)) begin
			send_item(MODE_CLEAR, $urandom_range(TB_LISTS - 1), 0);
		end else begin
			repeat (merge_sb.fill_total()) pop();
		end
	endtask

	// any mode, any index, unsorted values
	task automatic noise_round();
		repeat ($urandom_range(6, 14))
			send_item(MODE_W'($urandom_range(3)), $urandom_range(TB_LISTS - 1),
				longint'($signed($urandom)));
	endtask

	initial begin
		int roll;
		merge_sb = new();
		arst_n        <= 1'b0;
		item_if.valid <= 1'b0;
		item_if.data  <= '0;
		foreach (last_val[i])
			last_val[i] = 0;
		pick_phase();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, no-op, extremes, ties, clear, unsorted list
		pop();
		send_item(MODE_NOP, 7, -1);
		push(7, VMIN);
		push(0, VMAX);
		push(3, 5);
		push(1, 5);
		push(1, 5);
		push(5, -1);
		repeat (7) pop();
		push(2, 0);
		push(6, 0);
		send_item(MODE_CLEAR, 0, 0);
		pop();
		push(4, 7);
		push(4, 3);
		push(2, 4);
		repeat (3) pop();

		// random rounds
		while (items_sent < TOTAL_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 45)
				merge_round();
			else if (roll < 70)
				mixed_round();
			else if (roll < 82)
				noise_round();
			else if (roll < 92)
				overflow_round();
			else
				send_item(MODE_CLEAR, $urandom_range(TB_LISTS - 1),
					longint'($signed($urandom)));
		end
		item_if.valid <= 1'b0;

		// wait for the last results, then watch for strays
		while (!merge_sb.drained())
			@(posedge clk);
		repeat (4 * POP_LATENCY) @(posedge clk);

		if (merge_sb.mismatches == 0 && merge_sb.drained())
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

[k_way_sorted_merge_top.f]
rtl/core/kwm_pkg.sv
rtl/core/kwm_stream_if.sv
rtl/core/kwm_ctrl.sv
rtl/core/kwm_dpath.sv
rtl/core/k_way_sorted_merge_top.sv
tb/sv/kwm_tb_pkg.sv
tb/sv/tb_top.sv
